// ----- hw/rtl/ssym_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ssym_pkg
// Shared types and status codes for the sorted symbol table.
// ----------------------------------------------------------------------------
package ssym_pkg;

    localparam int STATUS_W = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 3'd0,
        ST_ABSENT    = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SRCH = 7'b0000010,
        S_CMP  = 7'b0000100,
        S_SHRD = 7'b0001000,
        S_SHWR = 7'b0010000,
        S_INS  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

endpackage
`default_nettype wire

// ----- hw/rtl/ssym_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ssym_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssym_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- hw/rtl/sorted_symbol_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_symbol_table
// Symbol table kept in ascending key order; binary search lookup and
// sorted insert over a single entry RAM.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_in_valid / o_in_stall) carries one command: a lookup
// or an add of a symbol. The output channel (o_out_valid / i_out_stall)
// returns one result per command: status, sorted index and stored fields.
// A transaction is taken when valid is high and stall is low.
// Steps: each search probe issues a RAM read in S_SRCH and compares the
// key in S_CMP. An add that inserts also moves every later entry up one
// slot, each move being one RAM read (S_SHRD) and one RAM write (S_SHWR),
// and then writes the new entry in S_INS.
// The single read and single write port of the entry RAM set this order.
// One command is in work at a time; o_in_stall is high while busy.
// Reset clears the entry count and the handshake state; the RAM is not
// cleared, since entries at or above the count are never read.
// A stalled receiver holds the result in the output register; a finished
// command waits in its final state until that register is free.
// ----------------------------------------------------------------------------
module sorted_symbol_table #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_CHARS   = 8,
    parameter int VALUE_BITS  = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_command,
    input  wire logic [63:0] i_symbol_key,
    input  wire logic [63:0] i_module_name,
    input  wire logic [15:0] i_location_value,
    input  wire logic [15:0] i_module_number,
    input  wire logic        i_absolute_mode,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_status,
    output logic [9:0]       o_entry_index,
    output logic [15:0]      o_entry_value,
    output logic [15:0]      o_entry_module_number,
    output logic             o_entry_relocatable,
    output logic [63:0]      o_entry_module_name
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int KW = 8 * KEY_CHARS;
    localparam int WW = KW + VALUE_BITS + 16 + 1 + 64;

    // word layout: key, value, module number, relocatable, module name
    localparam int MN_LO = 0;
    localparam int RL_LO = 64;
    localparam int MD_LO = 65;
    localparam int VL_LO = 81;
    localparam int KY_LO = 81 + VALUE_BITS;

    ssym_pkg::t_state  r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_lo, n_lo;
    logic [CW-1:0]     r_hi, n_hi;
    logic [CW-1:0]     r_mid, n_mid;
    logic [CW-1:0]     r_i, n_i;
    logic              r_add;
    logic [KW-1:0]     r_key;
    logic [WW-1:0]     r_new;

    ssym_pkg::t_status r_res_status, n_res_status;
    logic [WW-1:0]     r_res_word, n_res_word;
    logic [CW-1:0]     r_res_idx, n_res_idx;
    logic              r_res_hit, n_res_hit;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [WW-1:0]     w_wdata;
    logic [AW-1:0]     w_raddr;
    logic [WW-1:0]     w_rdata;
    logic [KW-1:0]     w_rkey;
    logic              w_in_take;
    logic              w_out_free;
    logic              w_load_out;

    ssym_ram #(
        .WIDTH(WW),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_rkey     = w_rdata[KY_LO +: KW];
    assign o_in_stall = (r_state != ssym_pkg::S_IDLE);
    assign w_in_take  = i_in_valid && !o_in_stall;
    assign w_out_free = !o_out_valid || !i_out_stall;
    assign w_load_out = (r_state == ssym_pkg::S_DONE) && w_out_free;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_i          = r_i;
        n_res_status = r_res_status;
        n_res_word   = r_res_word;
        n_res_idx    = r_res_idx;
        n_res_hit    = r_res_hit;
        w_we         = 1'b0;
        w_waddr      = AW'(r_i);
        w_wdata      = w_rdata;
        w_raddr      = AW'(r_mid);
        unique case (r_state)
            ssym_pkg::S_IDLE: begin
                if (w_in_take) begin
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_state = ssym_pkg::S_SRCH;
                end
            end
            ssym_pkg::S_SRCH: begin
                n_res_hit = 1'b0;
                if (r_lo < r_hi) begin
                    n_mid   = r_lo + ((r_hi - r_lo) >> 1);
                    w_raddr = AW'(n_mid);
                    n_state = ssym_pkg::S_CMP;
                end else if (!r_add) begin
                    n_res_status = ssym_pkg::ST_ABSENT;
                    n_state      = ssym_pkg::S_DONE;
                end else if (r_count == CW'(TABLE_DEPTH)) begin
                    n_res_status = ssym_pkg::ST_FULL;
                    n_state      = ssym_pkg::S_DONE;
                end else begin
                    n_i     = r_count;
                    n_state = (r_count == r_lo) ? ssym_pkg::S_INS : ssym_pkg::S_SHRD;
                end
            end
            ssym_pkg::S_CMP: begin
                if (w_rkey == r_key) begin
                    n_res_word = w_rdata;
                    n_res_idx  = r_mid;
                    if (r_add) begin
                        n_res_status = ssym_pkg::ST_DUPLICATE;
                    end else begin
                        n_res_status = ssym_pkg::ST_FOUND;
                        n_res_hit    = 1'b1;
                    end
                    n_state = ssym_pkg::S_DONE;
                end else begin
                    if (w_rkey < r_key) begin
                        n_lo = r_mid + 1'b1;
                    end else begin
                        n_hi = r_mid;
                    end
                    n_state = ssym_pkg::S_SRCH;
                end
            end
            ssym_pkg::S_SHRD: begin
                w_raddr = AW'(r_i - 1'b1);
                n_state = ssym_pkg::S_SHWR;
            end
            ssym_pkg::S_SHWR: begin
                // move entry i-1 up to slot i
                w_we    = 1'b1;
                w_waddr = AW'(r_i);
                w_wdata = w_rdata;
                n_i     = r_i - 1'b1;
                n_state = (n_i == r_lo) ? ssym_pkg::S_INS : ssym_pkg::S_SHRD;
            end
            ssym_pkg::S_INS: begin
                w_we         = 1'b1;
                w_waddr      = AW'(r_lo);
                w_wdata      = r_new;
                n_count      = r_count + 1'b1;
                n_res_status = ssym_pkg::ST_INSERTED;
                n_res_word   = r_new;
                n_res_idx    = r_lo;
                n_res_hit    = 1'b1;
                n_state      = ssym_pkg::S_DONE;
            end
            ssym_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = ssym_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ssym_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssym_pkg::S_IDLE;
            r_count     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load_out) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_i          <= n_i;
        r_res_status <= n_res_status;
        r_res_word   <= n_res_word;
        r_res_idx    <= n_res_idx;
        r_res_hit    <= n_res_hit;
        if (w_in_take) begin
            r_add <= i_command;
            r_key <= i_symbol_key[KW-1:0];
            r_new <= {i_symbol_key[KW-1:0], VALUE_BITS'(i_location_value),
                      i_module_number, !i_absolute_mode, i_module_name};
        end
        if (w_load_out) begin
            o_status <= r_res_status;
            if (r_res_hit) begin
                o_entry_index         <= 10'(r_res_idx);
                o_entry_value         <= 16'(r_res_word[VL_LO +: VALUE_BITS]);
                o_entry_module_number <= r_res_word[MD_LO +: 16];
                o_entry_relocatable   <= r_res_word[RL_LO];
                o_entry_module_name   <= r_res_word[MN_LO +: 64];
            end else begin
                o_entry_index         <= '0;
                o_entry_value         <= '0;
                o_entry_module_number <= '0;
                o_entry_relocatable   <= 1'b0;
                o_entry_module_name   <= '0;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == ssym_pkg::S_SHWR || r_state == ssym_pkg::S_INS))
        else $error("ram write outside shift or insert");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            ($past(r_state) == ssym_pkg::S_INS && r_count == $past(r_count) + 1'b1))
        else $error("entry count changed without insert");

    a_search_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssym_pkg::S_CMP) |-> (r_mid < r_count && r_lo <= r_mid))
        else $error("probe outside live entries");
`endif

endmodule
`default_nettype wire
